// File: rtl/core/sbq_pkg.sv
`timescale 1ns / 1ps

package sbq_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS = 32;
	localparam int CHANNELS = 2;

	localparam int COEF_FRAC = COEF_BITS - 4;
	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
	// five products summed plus the rounding offset
	localparam int ACC_BITS = PROD_BITS + 3;
	localparam int RSH_BITS = ACC_BITS - COEF_FRAC;
	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FF0 = 3'd0,
		REG_FF1 = 3'd1,
		REG_FF2 = 3'd2,
		REG_FB1 = 3'd3,
		REG_FB2 = 3'd4
	} sbq_reg_t;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] ff0;
		logic signed [COEF_BITS-1:0] ff1;
		logic signed [COEF_BITS-1:0] ff2;
		logic signed [COEF_BITS-1:0] fb1;
		logic signed [COEF_BITS-1:0] fb2;
	} sbq_coef_t;

	typedef struct packed {
		logic load;
		logic adv2;
		logic adv3;
		logic fire;
	} sbq_ctrl_t;

endpackage

// File: rtl/core/sbq_if.sv
`timescale 1ns / 1ps

interface sbq_in_if;
	import sbq_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;
	logic                          frame_last;

	modport source (output valid, output left_sample, output right_sample,
		output frame_last, input ready);
	modport sink (input valid, input left_sample, input right_sample,
		input frame_last, output ready);
endinterface

interface sbq_out_if;
	import sbq_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_filtered;
	logic signed [SAMPLE_BITS-1:0] right_filtered;
	logic                          frame_last_out;

	modport source (output valid, output left_filtered, output right_filtered,
		output frame_last_out, input ready);
	modport sink (input valid, input left_filtered, input right_filtered,
		input frame_last_out, output ready);
endinterface

// File: rtl/core/sbq_lane.sv
`timescale 1ns / 1ps

module sbq_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sbq_pkg::sbq_ctrl_t                    ctrl,
	input  sbq_pkg::sbq_coef_t                    coef,
	input  logic signed [sbq_pkg::SAMPLE_BITS-1:0] x,
	output logic signed [sbq_pkg::SAMPLE_BITS-1:0] y
);
	import sbq_pkg::*;

	localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) <<< (COEF_FRAC - 1);
	localparam logic signed [RSH_BITS-1:0] SMAX =
		RSH_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
	localparam logic signed [RSH_BITS-1:0] SMIN = -SMAX - RSH_BITS'(1);

	logic signed [SAMPLE_BITS-1:0] xh1_q, xh2_q;
	logic signed [SAMPLE_BITS-1:0] yh1_q, yh2_q;
	logic signed [SAMPLE_BITS-1:0] x0_s1, x1_s1, x2_s1;
	logic signed [PROD_BITS-1:0]   p0_s2, p1_s2, p2_s2;
	logic signed [ACC_BITS-1:0]    ffsum_s3;
	logic signed [PROD_BITS-1:0]   fb2p_q;
	logic signed [SAMPLE_BITS-1:0] y_q;

	logic signed [PROD_BITS-1:0]   fb1p;
	logic signed [ACC_BITS-1:0]    acc;
	logic signed [RSH_BITS-1:0]    rsh;
	logic signed [SAMPLE_BITS-1:0] ysat;

	// input history advances on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xh1_q <= '0;
			xh2_q <= '0;
		end else if (ctrl.load) begin
			xh1_q <= x;
			xh2_q <= xh1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x0_s1 <= x;
			x1_s1 <= xh1_q;
			x2_s1 <= xh2_q;
		end
		if (ctrl.adv2) begin
			p0_s2 <= x0_s1 * $signed(coef.ff0);
			p1_s2 <= x1_s1 * $signed(coef.ff1);
			p2_s2 <= x2_s1 * $signed(coef.ff2);
		end
		if (ctrl.adv3) begin
			ffsum_s3 <= ACC_BITS'(p0_s2) + ACC_BITS'(p1_s2) + ACC_BITS'(p2_s2);
		end
	end

	// feedback stage: only the one-frame-back product sits in this cycle
	always_comb begin
		fb1p = yh1_q * $signed(coef.fb1);
		acc  = ffsum_s3 - ACC_BITS'(fb2p_q) - ACC_BITS'(fb1p) + HALF;
		rsh  = RSH_BITS'(acc >>> COEF_FRAC);
		if (rsh > SMAX) begin
			ysat = SAMPLE_BITS'(SMAX);
		end else if (rsh < SMIN) begin
			ysat = SAMPLE_BITS'(SMIN);
		end else begin
			ysat = SAMPLE_BITS'(rsh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yh1_q  <= '0;
			yh2_q  <= '0;
			fb2p_q <= '0;
		end else if (ctrl.fire) begin
			yh1_q  <= ysat;
			yh2_q  <= yh1_q;
			fb2p_q <= yh1_q * $signed(coef.fb2);
		end else begin
			// refresh so a coefficient write is picked up while idle
			fb2p_q <= yh2_q * $signed(coef.fb2);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			y_q <= ysat;
		end
	end

	assign y = y_q;

endmodule

// File: rtl/core/stereo_biquad_filter_unit.sv
`timescale 1ns / 1ps
// Four-stage pipeline per channel lane: an accepted frame passes the input, product and
// feedforward-sum registers, then the feedback stage writes the output register.
// Throughput: one stereo frame per cycle unless frame_out stalls, set by the feedback
// stage (one 24x32 multiply, add, round and saturate per cycle).
// frame_in stays ready while the output word waits, as long as a stage is free.
// Reset clears stage valids and filter history; coefficients reset to unity pass-through.

module stereo_biquad_filter_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	sbq_in_if.sink                               frame_in,
	sbq_out_if.source                            frame_out,
	input  logic                                 cfg_we,
	input  logic [sbq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [sbq_pkg::COEF_BITS-1:0]        cfg_data
);
	import sbq_pkg::*;

	sbq_coef_t coef_q;
	sbq_ctrl_t ctrl;

	logic v1_q, v2_q, v3_q, ov_q;
	logic last_s1, last_s2, last_s3, last_q;
	logic ready_o, ready3, ready2, ready1;

	logic signed [SAMPLE_BITS-1:0] x_lane [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] y_lane [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.ff0 <= COEF_BITS'(1) << COEF_FRAC;
			coef_q.ff1 <= '0;
			coef_q.ff2 <= '0;
			coef_q.fb1 <= '0;
			coef_q.fb2 <= '0;
		end else if (cfg_we) begin
			case (sbq_reg_t'(cfg_index))
				REG_FF0: coef_q.ff0 <= cfg_data;
				REG_FF1: coef_q.ff1 <= cfg_data;
				REG_FF2: coef_q.ff2 <= cfg_data;
				REG_FB1: coef_q.fb1 <= cfg_data;
				REG_FB2: coef_q.fb2 <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage may take a word when empty or when its word moves on
	assign ready_o = !ov_q || frame_out.ready;
	assign ready3  = !v3_q || ready_o;
	assign ready2  = !v2_q || ready3;
	assign ready1  = !v1_q || ready2;
	assign frame_in.ready = ready1;

	assign ctrl.load = frame_in.valid && ready1;
	assign ctrl.adv2 = v1_q && ready2;
	assign ctrl.adv3 = v2_q && ready3;
	assign ctrl.fire = v3_q && ready_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (ctrl.load) begin
				v1_q <= 1'b1;
			end else if (ctrl.adv2) begin
				v1_q <= 1'b0;
			end
			if (ctrl.adv2) begin
				v2_q <= 1'b1;
			end else if (ctrl.adv3) begin
				v2_q <= 1'b0;
			end
			if (ctrl.adv3) begin
				v3_q <= 1'b1;
			end else if (ctrl.fire) begin
				v3_q <= 1'b0;
			end
			if (ctrl.fire) begin
				ov_q <= 1'b1;
			end else if (frame_out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			last_s1 <= frame_in.frame_last;
		end
		if (ctrl.adv2) begin
			last_s2 <= last_s1;
		end
		if (ctrl.adv3) begin
			last_s3 <= last_s2;
		end
		if (ctrl.fire) begin
			last_q <= last_s3;
		end
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		if (c == 0) begin : g_left
			assign x_lane[c] = frame_in.left_sample;
		end else if (c == 1) begin : g_right
			assign x_lane[c] = frame_in.right_sample;
		end else begin : g_spare
			assign x_lane[c] = '0;
		end

		sbq_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.coef   (coef_q),
			.x      (x_lane[c]),
			.y      (y_lane[c])
		);
	end

	// merge lanes into the output word
	assign frame_out.valid          = ov_q;
	assign frame_out.left_filtered  = y_lane[0];
	assign frame_out.frame_last_out = last_q;

	if (CHANNELS > 1) begin : g_out_right
		assign frame_out.right_filtered = y_lane[CHANNELS > 1 ? 1 : 0];
	end else begin : g_out_mono
		assign frame_out.right_filtered = '0;
	end

	a_empty_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.load && !v1_q && !v2_q && !v3_q && !ov_q) |-> ##4 frame_out.valid)
		else $error("frame through an empty pipe did not reach the output in time");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_in.ready |-> (v1_q && v2_q && v3_q && ov_q))
		else $error("input stalled while a stage was free");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(ov_q) |-> $past(frame_out.ready))
		else $error("output word dropped without handshake");

endmodule

// File: verif/stereo_biquad_filter_unit_tb.sv
`timescale 1ns / 1ps

module stereo_biquad_filter_unit_tb;
	import sbq_pkg::*;

	localparam int REG_COUNT = 5;
	localparam int RANDOM_FRAMES = 1450;
	localparam int SETTLE_CYCLES = 8;

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam longint LANE_MAX = (longint'(1) <<< (SAMPLE_BITS-1)) - 1;
	localparam longint LANE_MIN = -LANE_MAX - 1;

	localparam logic [COEF_BITS-1:0] C_ONE = COEF_BITS'(1) << COEF_FRAC;
	localparam logic [COEF_BITS-1:0] C_HALF = C_ONE >> 1;
	localparam logic [COEF_BITS-1:0] C_NEG_ONE = -C_ONE;
	localparam logic [COEF_BITS-1:0] C_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
	localparam logic [COEF_BITS-1:0] C_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
		logic                          last;
	} frame_result_t;

	typedef struct {
		bit                            is_cfg;
		logic [CFG_IDX_BITS-1:0]       idx;
		logic [COEF_BITS-1:0]          coef;
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
		logic                          last;
		bit                            typed;
		logic signed [SAMPLE_BITS-1:0] exp_left;
		logic signed [SAMPLE_BITS-1:0] exp_right;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [COEF_BITS-1:0] cfg_data;

	sbq_in_if  frame_in();
	sbq_out_if frame_out();

	stereo_biquad_filter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_in  (frame_in),
		.frame_out (frame_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// filter state as the block should hold it
	logic signed [COEF_BITS-1:0]   coef_bank [REG_COUNT];
	logic signed [SAMPLE_BITS-1:0] in_hist   [2][2];
	logic signed [SAMPLE_BITS-1:0] out_hist  [2][2];

	frame_result_t pending_frames[$];
	stim_row_t     dir_rows[$];
	int unsigned   mismatch_count = 0;
	bit            src_steady = 1'b0;
	bit            sink_steady = 1'b0;
	int unsigned   stall_left = 0;

	always #10 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] biquad_lane(int ch,
			logic signed [SAMPLE_BITS-1:0] x);
		longint acc;
		longint y;
		acc = longint'(coef_bank[REG_FF0]) * longint'(x)
			+ longint'(coef_bank[REG_FF1]) * longint'(in_hist[ch][0])
			+ longint'(coef_bank[REG_FF2]) * longint'(in_hist[ch][1])
			- longint'(coef_bank[REG_FB1]) * longint'(out_hist[ch][0])
			- longint'(coef_bank[REG_FB2]) * longint'(out_hist[ch][1]);
		// add half an output LSB, then floor: ties go up
		acc = acc + (longint'(1) <<< (COEF_FRAC - 1));
		y = acc >>> COEF_FRAC;
		if (y > LANE_MAX)
			y = LANE_MAX;
		else if (y < LANE_MIN)
			y = LANE_MIN;
		in_hist[ch][1] = in_hist[ch][0];
		in_hist[ch][0] = x;
		out_hist[ch][1] = out_hist[ch][0];
		out_hist[ch][0] = SAMPLE_BITS'(y);
		return SAMPLE_BITS'(y);
	endfunction

	function automatic frame_result_t biquad_predict(logic signed [SAMPLE_BITS-1:0] l,
			logic signed [SAMPLE_BITS-1:0] r, logic last);
		frame_result_t res;
		res.left = biquad_lane(0, l);
		res.right = '0;
		if (CHANNELS > 1)
			res.right = biquad_lane(1, r);
		res.last = last;
		return res;
	endfunction

	function automatic stim_row_t cfg_row(logic [CFG_IDX_BITS-1:0] idx,
			logic [COEF_BITS-1:0] data);
		stim_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.coef = data;
		return row;
	endfunction

	function automatic stim_row_t frame_row(logic signed [SAMPLE_BITS-1:0] l,
			logic signed [SAMPLE_BITS-1:0] r, logic last);
		stim_row_t row;
		row = '{default: '0};
		row.left = l;
		row.right = r;
		row.last = last;
		return row;
	endfunction

	function automatic stim_row_t frame_row_exp(logic signed [SAMPLE_BITS-1:0] l,
			logic signed [SAMPLE_BITS-1:0] r, logic last,
			logic signed [SAMPLE_BITS-1:0] el, logic signed [SAMPLE_BITS-1:0] er);
		stim_row_t row;
		row = frame_row(l, r, last);
		row.typed = 1'b1;
		row.exp_left = el;
		row.exp_right = er;
		return row;
	endfunction

	function automatic logic [COEF_BITS-1:0] pick_coef(int style, int k);
		logic [COEF_BITS-1:0] corner [5];
		corner = '{C_MAX, C_MIN, '0, C_ONE, C_NEG_ONE};
		if (style >= 7 && style <= 8)
			return corner[$urandom_range(0, 4)];
		if (style >= 5 && style <= 6)
			return COEF_BITS'($urandom);
		// roughly audio-like: gains within +-1, first feedback tap within +-2
		if (k == REG_FB1)
			return COEF_BITS'(longint'($urandom_range(0, 2 * C_ONE * 2)) - 2 * C_ONE);
		return COEF_BITS'(longint'($urandom_range(0, 2 * C_ONE)) - C_ONE);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return SAMPLE_BITS'($urandom);
		if (r < 75) begin
			case ($urandom_range(0, 4))
				0: return S_MAX;
				1: return S_MIN;
				2: return '0;
				3: return '1;
				default: return SAMPLE_BITS'(1);
			endcase
		end
		return SAMPLE_BITS'(int'($urandom_range(0, 4095)) - 2048);
	endfunction

	task automatic send_frame(input stim_row_t row);
		int unsigned gap;
		frame_result_t want;
		gap = src_steady ? 0 : pick_gap();
		if (gap != 0) begin
			frame_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_in.valid <= 1'b1;
		frame_in.left_sample <= row.left;
		frame_in.right_sample <= row.right;
		frame_in.frame_last <= row.last;
		do @(posedge clk); while (frame_in.ready !== 1'b1);
		want = biquad_predict(row.left, row.right, row.last);
		if (row.typed) begin
			want.left = row.exp_left;
			want.right = row.exp_right;
		end
		pending_frames.push_back(want);
	endtask

	// hold off until the pipeline is empty
	task automatic drain_frames();
		frame_in.valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [COEF_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx < REG_COUNT)
			coef_bank[idx] = data;
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			frame_out.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			frame_out.ready <= 1'b1;
			if (!sink_steady)
				stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && frame_out.valid === 1'b1 && frame_out.ready === 1'b1) begin
			if (pending_frames.size() == 0) begin
				$display("%0t: unexpected word: left %0d right %0d last %b", $time,
					frame_out.left_filtered, frame_out.right_filtered,
					frame_out.frame_last_out);
				mismatch_count++;
			end else begin
				want = pending_frames.pop_front();
				if (frame_out.left_filtered !== want.left) begin
					$display("%0t: left_filtered expected %0d actual %0d", $time,
						want.left, frame_out.left_filtered);
					mismatch_count++;
				end
				if (frame_out.right_filtered !== want.right) begin
					$display("%0t: right_filtered expected %0d actual %0d", $time,
						want.right, frame_out.right_filtered);
					mismatch_count++;
				end
				if (frame_out.frame_last_out !== want.last) begin
					$display("%0t: frame_last_out expected %b actual %b", $time,
						want.last, frame_out.frame_last_out);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("stereo_biquad_filter_unit verification failed");
		$finish;
	end

	initial begin
		bit cfg_open;
		int style;
		int unsigned random_sent;
		int unsigned n_frames;
		stim_row_t row;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		frame_in.valid = 1'b0;
		frame_in.left_sample = '0;
		frame_in.right_sample = '0;
		frame_in.frame_last = 1'b0;
		frame_out.ready = 1'b0;

		coef_bank = '{C_ONE, '0, '0, '0, '0};
		in_hist = '{default: '0};
		out_hist = '{default: '0};

		// unity pass-through out of reset
		dir_rows.push_back(frame_row_exp('0, '0, 1'b0, '0, '0));
		dir_rows.push_back(frame_row_exp(S_MAX, S_MIN, 1'b1, S_MAX, S_MIN));
		dir_rows.push_back(frame_row_exp(S_MIN, S_MAX, 1'b0, S_MIN, S_MAX));
		dir_rows.push_back(frame_row_exp('1, SAMPLE_BITS'(1), 1'b0, '1, SAMPLE_BITS'(1)));
		dir_rows.push_back(frame_row_exp(24'h555555, 24'haaaaaa, 1'b1, 24'h555555, 24'haaaaaa));
		// largest gain saturates both ways
		dir_rows.push_back(cfg_row(REG_FF0, C_MAX));
		dir_rows.push_back(frame_row_exp(S_MAX, S_MIN, 1'b0, S_MAX, S_MIN));
		dir_rows.push_back(frame_row(SAMPLE_BITS'(1), '1, 1'b0));
		dir_rows.push_back(cfg_row(REG_FF0, C_MIN));
		dir_rows.push_back(frame_row_exp(S_MIN, S_MAX, 1'b1, S_MAX, S_MIN));
		// half gain: ties round toward plus infinity
		dir_rows.push_back(cfg_row(REG_FF0, C_HALF));
		dir_rows.push_back(frame_row_exp(SAMPLE_BITS'(1), '1, 1'b0, SAMPLE_BITS'(1), '0));
		dir_rows.push_back(frame_row_exp(SAMPLE_BITS'(3), -SAMPLE_BITS'(3), 1'b0,
			SAMPLE_BITS'(2), '1));
		// feedforward taps
		dir_rows.push_back(cfg_row(REG_FF0, C_ONE));
		dir_rows.push_back(cfg_row(REG_FF1, C_ONE));
		dir_rows.push_back(cfg_row(REG_FF2, C_HALF));
		dir_rows.push_back(frame_row(24'h100000, -24'sd4096, 1'b0));
		dir_rows.push_back(frame_row(24'h300000, 24'h7ff000, 1'b0));
		dir_rows.push_back(frame_row(-24'sd77, 24'h700000, 1'b1));
		// resonator: y = x + y1 - y2, then driven into saturation
		dir_rows.push_back(cfg_row(REG_FF1, '0));
		dir_rows.push_back(cfg_row(REG_FF2, '0));
		dir_rows.push_back(cfg_row(REG_FB1, C_NEG_ONE));
		dir_rows.push_back(cfg_row(REG_FB2, C_ONE));
		dir_rows.push_back(frame_row(24'sd4096, -24'sd4096, 1'b0));
		dir_rows.push_back(frame_row('0, '0, 1'b0));
		dir_rows.push_back(frame_row(S_MAX, S_MIN, 1'b0));
		dir_rows.push_back(frame_row(S_MAX, S_MIN, 1'b0));
		dir_rows.push_back(cfg_row(REG_FB1, C_MAX));
		dir_rows.push_back(cfg_row(REG_FB2, C_MIN));
		dir_rows.push_back(frame_row(S_MIN, S_MAX, 1'b0));
		dir_rows.push_back(frame_row(24'sd1000, 24'sd1000, 1'b1));
		// back to pass-through, then spare indexes must leave it alone
		dir_rows.push_back(cfg_row(REG_FF0, C_ONE));
		dir_rows.push_back(cfg_row(REG_FF1, '0));
		dir_rows.push_back(cfg_row(REG_FF2, '0));
		dir_rows.push_back(cfg_row(REG_FB1, '0));
		dir_rows.push_back(cfg_row(REG_FB2, '0));
		for (int k = REG_COUNT; k < 2 ** CFG_IDX_BITS; k++)
			dir_rows.push_back(cfg_row(CFG_IDX_BITS'(k), '1));
		dir_rows.push_back(frame_row_exp(24'h123456, -24'sh654321, 1'b0,
			24'h123456, -24'sh654321));
		dir_rows.push_back(frame_row_exp(S_MIN, S_MAX, 1'b1, S_MIN, S_MAX));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cfg_open = 1'b0;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				if (!cfg_open)
					drain_frames();
				cfg_put(dir_rows[i].idx, dir_rows[i].coef);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) begin
					cfg_we <= 1'b0;
					cfg_open = 1'b0;
				end
				send_frame(dir_rows[i]);
			end
		end

		random_sent = 0;
		while (random_sent < RANDOM_FRAMES) begin
			drain_frames();
			style = $urandom_range(0, 9);
			for (int k = 0; k < REG_COUNT; k++)
				if (style != 9 || $urandom_range(0, 1) == 1)
					cfg_put(CFG_IDX_BITS'(k), pick_coef(style, k));
			if ($urandom_range(0, 5) == 0)
				cfg_put(CFG_IDX_BITS'(REG_COUNT + $urandom_range(0, 2)), COEF_BITS'($urandom));
			cfg_we <= 1'b0;

			src_steady = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			n_frames = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8)
				: $urandom_range(20, 160);
			repeat (n_frames) begin
				row = frame_row(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
				send_frame(row);
				random_sent++;
				if ($urandom_range(0, 299) == 0)
					drain_frames();
			end
		end

		drain_frames();
		if (mismatch_count == 0)
			$display("stereo_biquad_filter_unit verification clean");
		else
			$display("stereo_biquad_filter_unit verification failed");
		$finish;
	end

endmodule
